// ===== rtl/rle_sprite_palette_blitter_core_assert.svh =====
// assertion macros for the blitter rtl
// expects clk and rst_n in the scope of each use
`ifndef RLE_SPRITE_PALETTE_BLITTER_CORE_ASSERT_SVH
`define RLE_SPRITE_PALETTE_BLITTER_CORE_ASSERT_SVH

// plain property under the module clock and reset
`define RSP_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// a value must not change in the cycle after cond
`define RSP_HOLD(lbl, cond, sig, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) \
        else $error(msg);

`endif

// ===== rtl/rsp_pkg.sv =====
// shared types and constants for the run-length sprite blitter
// no dependencies
`timescale 1ns / 1ps

package rsp_pkg;

    localparam int COORD_BITS  = 13;
    localparam int PAL_ENTRIES = 256;
    localparam int PAL_AW      = (PAL_ENTRIES > 1) ? $clog2(PAL_ENTRIES) : 1;

    localparam int CODE_W   = 8;
    localparam int COLOR_W  = 24;
    localparam int ADDR_W   = 26;
    localparam int FRAME_W  = 13;
    localparam int STRIDE_W = 14;
    localparam int SPR_W    = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 14;

    localparam logic [CODE_W-1:0] CODE_END = 8'hFF;
    localparam logic [CODE_W-1:0] CODE_ROW = 8'hFE;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_STRIDE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ANCHOR       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPRITE_W     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPRITE_H     = 3'd7;

    localparam logic [FRAME_W-1:0]  RST_FRAME_WIDTH  = 13'd640;
    localparam logic [FRAME_W-1:0]  RST_FRAME_HEIGHT = 13'd480;
    localparam logic [STRIDE_W-1:0] RST_ROW_STRIDE   = 14'd1920;

    typedef struct packed {
        logic signed [FRAME_W-1:0] origin_x;
        logic signed [FRAME_W-1:0] origin_y;
        logic [FRAME_W-1:0]        frame_width;
        logic [FRAME_W-1:0]        frame_height;
        logic [STRIDE_W-1:0]       row_stride;
        logic                      anchor;
        logic [SPR_W-1:0]          sprite_width;
        logic [SPR_W-1:0]          sprite_height;
    } cfg_t;

    // one pixel or marker request from the parser
    typedef struct packed {
        logic                  emit;
        logic                  kind;
        logic [COORD_BITS-1:0] col;
        logic [COORD_BITS-1:0] row;
    } pix_req_t;

endpackage

// ===== rtl/rsp_parser.sv =====
// run-length stream parser: phase, column, row and pixel count
// depends on rsp_pkg
`timescale 1ns / 1ps

module rsp_parser (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       accept,
    input  logic                       opcode,
    input  logic [rsp_pkg::CODE_W-1:0] code_byte,
    output rsp_pkg::pix_req_t          req
);

    typedef enum logic [1:0] {PH_CMD, PH_COUNT, PH_PIXELS} phase_t;

    phase_t                         phase_reg, phase_next;
    logic [rsp_pkg::COORD_BITS-1:0] col_reg, col_next;
    logic [rsp_pkg::COORD_BITS-1:0] row_reg, row_next;
    logic [rsp_pkg::CODE_W-1:0]     left_reg, left_next;
    logic [rsp_pkg::CODE_W-1:0]     left_dec;

    assign left_dec = left_reg - 1'b1;

    always_comb
    begin
        phase_next = phase_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        left_next  = left_reg;
        req.emit   = 1'b0;
        req.kind   = 1'b0;
        req.col    = col_reg;
        req.row    = row_reg;
        if (accept && !opcode)
        begin
            unique case (phase_reg)
                PH_COUNT:
                begin
                    left_next  = code_byte;
                    phase_next = (code_byte == '0) ? PH_CMD : PH_PIXELS;
                end
                PH_PIXELS:
                begin
                    req.emit  = 1'b1;
                    col_next  = col_reg + 1'b1;
                    left_next = left_dec;
                    if (left_dec == '0)
                        phase_next = PH_CMD;
                end
                default:
                begin
                    phase_next = PH_CMD;
                    if (code_byte == rsp_pkg::CODE_END)
                    begin
                        col_next  = '0;
                        row_next  = '0;
                        left_next = '0;
                        req.emit  = 1'b1;
                        req.kind  = 1'b1;
                    end
                    else if (code_byte == rsp_pkg::CODE_ROW)
                    begin
                        col_next = '0;
                        row_next = row_reg + 1'b1;
                    end
                    else
                    begin
                        // skip count
                        col_next   = col_reg + rsp_pkg::COORD_BITS'(code_byte);
                        phase_next = PH_COUNT;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_CMD;
            col_reg   <= '0;
            row_reg   <= '0;
            left_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            left_reg  <= left_next;
        end
    end

endmodule

// ===== rtl/rsp_palette.sv =====
// palette memory with per-entry valid bits so unwritten entries read zero
// depends on rsp_pkg
`timescale 1ns / 1ps

module rsp_palette (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        wr_en,
    input  logic [rsp_pkg::CODE_W-1:0]  wr_slot,
    input  logic [rsp_pkg::COLOR_W-1:0] wr_color,
    input  logic                        rd_en,
    input  logic [rsp_pkg::CODE_W-1:0]  rd_slot,
    output logic [rsp_pkg::COLOR_W-1:0] rd_color
);

    logic [rsp_pkg::COLOR_W-1:0] mem [rsp_pkg::PAL_ENTRIES];
    logic [rsp_pkg::PAL_ENTRIES-1:0] valid_reg;
    logic [rsp_pkg::COLOR_W-1:0] rd_data_reg;
    logic                        rd_hit_reg;
    logic                        wr_in_range;
    logic                        rd_in_range;
    logic [rsp_pkg::PAL_AW-1:0]  wr_idx;
    logic [rsp_pkg::PAL_AW-1:0]  rd_idx;

    assign wr_in_range = {1'b0, wr_slot} < (rsp_pkg::CODE_W + 1)'(rsp_pkg::PAL_ENTRIES);
    assign rd_in_range = {1'b0, rd_slot} < (rsp_pkg::CODE_W + 1)'(rsp_pkg::PAL_ENTRIES);
    assign wr_idx = wr_slot[rsp_pkg::PAL_AW-1:0];
    assign rd_idx = rd_slot[rsp_pkg::PAL_AW-1:0];

    always_ff @(posedge clk)
    begin
        if (wr_en && wr_in_range)
            mem[wr_idx] <= wr_color;
        if (rd_en)
            rd_data_reg <= mem[rd_idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_hit_reg <= 1'b0;
        end
        else
        begin
            if (wr_en && wr_in_range)
                valid_reg[wr_idx] <= 1'b1;
            if (rd_en)
                rd_hit_reg <= rd_in_range && valid_reg[rd_idx];
        end
    end

    assign rd_color = rd_hit_reg ? rd_data_reg : '0;

endmodule

// ===== rtl/rsp_pixel_pipe.sv =====
// request stage, clip stage and address output register with backpressure
// depends on rsp_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "rle_sprite_palette_blitter_core_assert.svh"

module rsp_pixel_pipe (
    input  logic                        clk,
    input  logic                        rst_n,
    input  rsp_pkg::cfg_t               cfg,
    input  logic                        in_load,
    input  rsp_pkg::pix_req_t           req,
    input  logic [rsp_pkg::COLOR_W-1:0] pal_color,
    output logic                        s1_ready,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        kind,
    output logic [rsp_pkg::ADDR_W-1:0]  byte_address,
    output logic [rsp_pkg::COLOR_W-1:0] pixel_color
);

    localparam int SUM_W = ((rsp_pkg::COORD_BITS > 14) ? rsp_pkg::COORD_BITS : 14) + 2;
    localparam int FW    = rsp_pkg::FRAME_W;

    // stage 1: request held while the palette read completes
    logic                           s1_valid_reg;
    logic                           s1_kind_reg;
    logic [rsp_pkg::COORD_BITS-1:0] s1_col_reg;
    logic [rsp_pkg::COORD_BITS-1:0] s1_row_reg;

    // stage 2: clipped coordinates and colour
    logic                        s2_valid_reg;
    logic                        s2_kind_reg;
    logic [FW-1:0]               s2_px_reg;
    logic [FW-1:0]               s2_py_reg;
    logic [rsp_pkg::COLOR_W-1:0] s2_color_reg;

    // output word
    logic                        out_valid_reg;
    logic                        kind_reg;
    logic [rsp_pkg::ADDR_W-1:0]  addr_reg;
    logic [rsp_pkg::COLOR_W-1:0] color_reg;

    logic             s3_free;
    logic             s2_ready;
    logic [SUM_W-1:0] ax, ay, px, py;
    logic             in_frame;
    logic [2*FW:0]    row_prod;
    logic [FW+1:0]    px_times3;
    logic [rsp_pkg::ADDR_W-1:0] addr_next;

    assign s3_free  = !out_valid_reg || !out_stall;
    assign s2_ready = !s2_valid_reg || s3_free;
    assign s1_ready = !s1_valid_reg || s2_ready;

    // anchored origin, then frame test
    always_comb
    begin
        ax = {{(SUM_W-FW){cfg.origin_x[FW-1]}}, cfg.origin_x};
        ay = {{(SUM_W-FW){cfg.origin_y[FW-1]}}, cfg.origin_y};
        if (cfg.anchor)
        begin
            ax = ax - {{(SUM_W-rsp_pkg::SPR_W+1){1'b0}}, cfg.sprite_width[rsp_pkg::SPR_W-1:1]};
            ay = ay - {{(SUM_W-rsp_pkg::SPR_W){1'b0}}, cfg.sprite_height};
        end
        px = ax + {{(SUM_W-rsp_pkg::COORD_BITS){1'b0}}, s1_col_reg};
        py = ay + {{(SUM_W-rsp_pkg::COORD_BITS){1'b0}}, s1_row_reg};
        in_frame = !px[SUM_W-1] && !py[SUM_W-1]
                && (px < {{(SUM_W-FW){1'b0}}, cfg.frame_width})
                && (py < {{(SUM_W-FW){1'b0}}, cfg.frame_height});
    end

    assign row_prod  = {{(2*FW+1-rsp_pkg::STRIDE_W){1'b0}}, cfg.row_stride}
                     * {{(FW+1){1'b0}}, s2_py_reg};
    assign px_times3 = {1'b0, s2_px_reg, 1'b0} + {2'b00, s2_px_reg};
    assign addr_next = row_prod[rsp_pkg::ADDR_W-1:0]
                     + {{(rsp_pkg::ADDR_W-FW-2){1'b0}}, px_times3};

    always_ff @(posedge clk)
    begin
        if (in_load && req.emit)
        begin
            s1_kind_reg <= req.kind;
            s1_col_reg  <= req.col;
            s1_row_reg  <= req.row;
        end
        if (s1_valid_reg && s2_ready)
        begin
            s2_kind_reg  <= s1_kind_reg;
            s2_px_reg    <= s1_kind_reg ? '0 : px[FW-1:0];
            s2_py_reg    <= s1_kind_reg ? '0 : py[FW-1:0];
            s2_color_reg <= s1_kind_reg ? '0 : pal_color;
        end
        if (s2_valid_reg && s3_free)
        begin
            kind_reg  <= s2_kind_reg;
            addr_reg  <= addr_next;
            color_reg <= s2_color_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_load && req.emit)
                s1_valid_reg <= 1'b1;
            else if (s2_ready)
                s1_valid_reg <= 1'b0;
            if (s2_ready)
                s2_valid_reg <= s1_valid_reg && (s1_kind_reg || in_frame);
            if (s3_free)
                out_valid_reg <= s2_valid_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign kind         = kind_reg;
    assign byte_address = addr_reg;
    assign pixel_color  = color_reg;

    `RSP_CHECK(a_load_room, in_load |-> s1_ready, "word accepted with stage 1 blocked")
    `RSP_CHECK(a_marker_zero, (out_valid && kind) |-> (byte_address == '0 && pixel_color == '0),
        "finish marker carries address or colour")
    `RSP_HOLD(a_s2_hold, s2_valid_reg && !s3_free, {s2_kind_reg, s2_px_reg, s2_py_reg, s2_color_reg},
        "stage 2 changed while blocked")

endmodule

// ===== rtl/rle_sprite_palette_blitter_core.sv =====
// top level of the run-length sprite blitter: config registers and wiring
// depends on rsp_pkg, rsp_parser, rsp_palette, rsp_pixel_pipe
`timescale 1ns / 1ps

// channel | handshake          | payload
// in      | in_valid/in_stall  | opcode, code_byte, palette_slot, palette_color
// out     | out_valid/out_stall| kind, byte_address, pixel_color
// cfg     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// one input word per cycle while in_stall is low; a pixel or marker passes three
// registers to the output (palette read, then clip, then stride multiply)
// words that give no result only update the parser or the palette
// out_stall backs up through the three stages and then raises in_stall
// reset clears parser state, palette valid bits and pipeline valid flags at once and loads the config defaults

module rle_sprite_palette_blitter_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           opcode,
    input  logic [rsp_pkg::CODE_W-1:0]     code_byte,
    input  logic [rsp_pkg::CODE_W-1:0]     palette_slot,
    input  logic [rsp_pkg::COLOR_W-1:0]    palette_color,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           kind,
    output logic [rsp_pkg::ADDR_W-1:0]     byte_address,
    output logic [rsp_pkg::COLOR_W-1:0]    pixel_color,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [rsp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rsp_pkg::CFG_DATA_W-1:0] cfg_data
);

    rsp_pkg::cfg_t     cfg_reg;
    rsp_pkg::pix_req_t req;
    logic              accept;
    logic              s1_ready;
    logic [rsp_pkg::COLOR_W-1:0] pal_color;

    assign cfg_ready = 1'b1;
    assign in_stall  = !s1_ready;
    assign accept    = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.origin_x      <= '0;
            cfg_reg.origin_y      <= '0;
            cfg_reg.frame_width   <= rsp_pkg::RST_FRAME_WIDTH;
            cfg_reg.frame_height  <= rsp_pkg::RST_FRAME_HEIGHT;
            cfg_reg.row_stride    <= rsp_pkg::RST_ROW_STRIDE;
            cfg_reg.anchor        <= 1'b0;
            cfg_reg.sprite_width  <= '0;
            cfg_reg.sprite_height <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                rsp_pkg::REG_ORIGIN_X:
                    cfg_reg.origin_x <= $signed(cfg_data[rsp_pkg::FRAME_W-1:0]);
                rsp_pkg::REG_ORIGIN_Y:
                    cfg_reg.origin_y <= $signed(cfg_data[rsp_pkg::FRAME_W-1:0]);
                rsp_pkg::REG_FRAME_WIDTH:
                    cfg_reg.frame_width <= cfg_data[rsp_pkg::FRAME_W-1:0];
                rsp_pkg::REG_FRAME_HEIGHT:
                    cfg_reg.frame_height <= cfg_data[rsp_pkg::FRAME_W-1:0];
                rsp_pkg::REG_ROW_STRIDE:
                    cfg_reg.row_stride <= cfg_data[rsp_pkg::STRIDE_W-1:0];
                rsp_pkg::REG_ANCHOR:
                    cfg_reg.anchor <= cfg_data[0];
                rsp_pkg::REG_SPRITE_W:
                    cfg_reg.sprite_width <= cfg_data[rsp_pkg::SPR_W-1:0];
                rsp_pkg::REG_SPRITE_H:
                    cfg_reg.sprite_height <= cfg_data[rsp_pkg::SPR_W-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    rsp_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .opcode    (opcode),
        .code_byte (code_byte),
        .req       (req)
    );

    // pixel index is the code byte itself
    rsp_palette u_palette (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (accept && opcode),
        .wr_slot  (palette_slot),
        .wr_color (palette_color),
        .rd_en    (req.emit && !req.kind),
        .rd_slot  (code_byte),
        .rd_color (pal_color)
    );

    rsp_pixel_pipe u_pipe (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .in_load      (accept),
        .req          (req),
        .pal_color    (pal_color),
        .s1_ready     (s1_ready),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .byte_address (byte_address),
        .pixel_color  (pixel_color)
    );

endmodule
